[design/osa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osa_pkg: shared types and constants
// Item layouts, operation and status codes, and controller/datapath links
// for the operand stack ALU.
// ----------------------------------------------------------------------------
package osa_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned FUNC_W          = 4;
  localparam int unsigned DEPTH_W         = 7;
  localparam int unsigned STATUS_W        = 3;

  localparam logic [FUNC_W-1:0] FN_PUSH  = 4'd0;
  localparam logic [FUNC_W-1:0] FN_ADD   = 4'd1;
  localparam logic [FUNC_W-1:0] FN_SUB   = 4'd2;
  localparam logic [FUNC_W-1:0] FN_MUL   = 4'd3;
  localparam logic [FUNC_W-1:0] FN_DIV   = 4'd4;
  localparam logic [FUNC_W-1:0] FN_EQ    = 4'd5;
  localparam logic [FUNC_W-1:0] FN_NEQ   = 4'd6;
  localparam logic [FUNC_W-1:0] FN_GT    = 4'd7;
  localparam logic [FUNC_W-1:0] FN_GE    = 4'd8;
  localparam logic [FUNC_W-1:0] FN_LT    = 4'd9;
  localparam logic [FUNC_W-1:0] FN_LE    = 4'd10;
  localparam logic [FUNC_W-1:0] FN_POP   = 4'd11;
  localparam logic [FUNC_W-1:0] FN_EXCH  = 4'd12;
  localparam logic [FUNC_W-1:0] FN_DUP   = 4'd13;
  localparam logic [FUNC_W-1:0] FN_INDEX = 4'd14;

  localparam logic [STATUS_W-1:0] STS_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STS_UNDER    = 3'd1;
  localparam logic [STATUS_W-1:0] STS_OVER     = 3'd2;
  localparam logic [STATUS_W-1:0] STS_DIVZERO  = 3'd3;
  localparam logic [STATUS_W-1:0] STS_BADINDEX = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] literal;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic [DEPTH_W-1:0]       depth;
    logic [STATUS_W-1:0]      status;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exch_lo;
    logic mul_cap;
    logic div_start;
    logic idx_rd;
    logic commit;
    logic late;
  } osa_cmd_t;

  typedef struct packed {
    logic err;
    logic is_mul;
    logic is_div;
    logic is_idx;
    logic is_exch;
    logic out_free;
    logic div_done;
  } osa_sts_t;

endpackage

`default_nettype wire

[design/operand_stack_alu_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// operand_stack_alu_top: stack machine execution unit
// Runs one stack operation per item over a STACK_DEPTH-entry operand stack
// and returns the new top, depth and status.
// ----------------------------------------------------------------------------
// One item is in flight at a time; the stack memory has one write port and
// two registered read ports. push, add, sub, the comparisons, pop, dup,
// unused codes and any failing operation go through read, execute and
// commit; mul, exch and index add a step before commit (registered product,
// second write to the store, or the indexed read); div waits for the
// divider, which gives one quotient bit per cycle. A waiting result holds
// the next item only at its commit cycle. The store needs no clearing after reset.
module operand_stack_alu_top import osa_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_item
);

  osa_cmd_t cmd;
  osa_sts_t sts;

  osa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  osa_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

[design/osa_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osa_div: signed divider
// Radix-2 restoring division on magnitudes, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module osa_div import osa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [DATA_W-1:0] divisor,
  output logic                   done,
  output logic [DATA_W-1:0]      quotient
);

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] dv_r;
  logic              neg_r;
  logic [DATA_W:0]   shifted;
  logic [DATA_W+1:0] diff;

  always_comb begin
    shifted = {rem_r, quo_r[DATA_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dv_r};
    rem_nxt = diff[DATA_W+1] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
    quo_nxt = {quo_r[DATA_W-2:0], ~diff[DATA_W+1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DATA_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
      dv_r  <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
      neg_r <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (DATA_W'(0) - quo_r) : quo_r;

endmodule

`default_nettype wire

[design/osa_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osa_ctrl: operation sequencer
// Steps each item through stack read, execute, the longer operations and
// result commit.
// ----------------------------------------------------------------------------
module osa_ctrl import osa_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire osa_sts_t sts,
  output osa_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_LATE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts.err && sts.is_mul) begin
          cmd.mul_cap = 1'b1;
          state_nxt   = S_LATE;
        end else if (!sts.err && sts.is_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else if (!sts.err && sts.is_idx) begin
          cmd.idx_rd = 1'b1;
          state_nxt  = S_LATE;
        end else if (!sts.err && sts.is_exch) begin
          cmd.exch_lo = 1'b1;
          state_nxt   = S_LATE;
        end else if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_LATE;
        end
      end
      S_LATE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          cmd.late   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[design/osa_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osa_dp: stack datapath
// Stack memory, stack pointer, ALU, multiplier, divider and output register.
// ----------------------------------------------------------------------------
module osa_dp import osa_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_item_t in_item,
  output out_item_t     out_item,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire osa_cmd_t cmd,
  output osa_sts_t      sts
);

  localparam int unsigned ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SP_W   = $clog2(STACK_DEPTH + 1);

  logic [DATA_W-1:0] mem [STACK_DEPTH];

  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic [FUNC_W-1:0] func_r;
  logic [DATA_W-1:0] lit_r;
  logic [DATA_W-1:0] rd_a_r, rd_b_r;
  logic [DATA_W-1:0] prod_r;
  out_item_t         out_item_r;
  logic              out_valid_r;

  logic [ADDR_W-1:0] addr_a, addr_b, idx_addr, waddr;
  logic [SP_W-1:0]   idx_sp;
  logic [DATA_W-1:0] wdata, alu_c, bin_val, top_c, quot;
  logic              we, is_bin, empty, lt2, full, bad_idx, div_done, ok;
  logic [STATUS_W-1:0] err_c, status_c;

  // rd_a holds T, rd_b holds S; rd_a is reused for the index read
  assign empty   = (sp_r == '0);
  assign lt2     = (sp_r < SP_W'(2));
  assign full    = (sp_r == SP_W'(STACK_DEPTH));
  assign is_bin  = (func_r >= FN_ADD) && (func_r <= FN_LE);
  assign bad_idx = rd_a_r[DATA_W-1] || (rd_a_r >= DATA_W'(sp_r - SP_W'(1)));
  assign idx_sp  = sp_r - SP_W'(2) - rd_a_r[SP_W-1:0];
  assign idx_addr = idx_sp[ADDR_W-1:0];
  assign addr_a  = cmd.idx_rd ? idx_addr : ADDR_W'(sp_r - SP_W'(1));
  assign addr_b  = ADDR_W'(sp_r - SP_W'(2));

  always_comb begin
    err_c = STS_OK;
    case (func_r)
      FN_PUSH:  if (full) err_c = STS_OVER;
      FN_POP:   if (empty) err_c = STS_UNDER;
      FN_EXCH:  if (lt2) err_c = STS_UNDER;
      FN_DUP: begin
        if (empty) err_c = STS_UNDER;
        else if (full) err_c = STS_OVER;
      end
      FN_INDEX: begin
        if (empty) err_c = STS_UNDER;
        else if (bad_idx) err_c = STS_BADINDEX;
      end
      default: begin
        if (is_bin) begin
          if (lt2) err_c = STS_UNDER;
          else if (func_r == FN_DIV && rd_a_r == '0) err_c = STS_DIVZERO;
        end
      end
    endcase
  end

  always_comb begin
    alu_c = '0;
    case (func_r)
      FN_ADD: alu_c = rd_b_r + rd_a_r;
      FN_SUB: alu_c = rd_b_r - rd_a_r;
      FN_EQ:  alu_c = DATA_W'(rd_b_r == rd_a_r);
      FN_NEQ: alu_c = DATA_W'(rd_b_r != rd_a_r);
      FN_GT:  alu_c = DATA_W'($signed(rd_b_r) >  $signed(rd_a_r));
      FN_GE:  alu_c = DATA_W'($signed(rd_b_r) >= $signed(rd_a_r));
      FN_LT:  alu_c = DATA_W'($signed(rd_b_r) <  $signed(rd_a_r));
      FN_LE:  alu_c = DATA_W'($signed(rd_b_r) <= $signed(rd_a_r));
      default: alu_c = '0;
    endcase
  end

  assign bin_val  = (func_r == FN_MUL) ? prod_r : ((func_r == FN_DIV) ? quot : alu_c);
  assign status_c = cmd.late ? STS_OK : err_c;
  assign ok       = (status_c == STS_OK);

  always_comb begin
    we     = 1'b0;
    waddr  = ADDR_W'(sp_r - SP_W'(1));
    wdata  = rd_b_r;
    sp_nxt = sp_r;
    top_c  = empty ? '0 : rd_a_r;
    if (cmd.exch_lo) begin
      we    = 1'b1;
      waddr = addr_b;
      wdata = rd_a_r;
    end else if (cmd.commit && ok) begin
      case (func_r)
        FN_PUSH: begin
          we     = 1'b1;
          waddr  = ADDR_W'(sp_r);
          wdata  = lit_r;
          sp_nxt = sp_r + SP_W'(1);
          top_c  = lit_r;
        end
        FN_POP: begin
          sp_nxt = sp_r - SP_W'(1);
          top_c  = lt2 ? '0 : rd_b_r;
        end
        FN_EXCH: begin
          we    = 1'b1;
          wdata = rd_b_r;
          top_c = rd_b_r;
        end
        FN_DUP: begin
          we     = 1'b1;
          waddr  = ADDR_W'(sp_r);
          wdata  = rd_a_r;
          sp_nxt = sp_r + SP_W'(1);
          top_c  = rd_a_r;
        end
        FN_INDEX: begin
          we    = 1'b1;
          wdata = rd_a_r;
          top_c = rd_a_r;
        end
        default: begin
          if (is_bin) begin
            we     = 1'b1;
            waddr  = addr_b;
            wdata  = bin_val;
            sp_nxt = sp_r - SP_W'(1);
            top_c  = bin_val;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.load || cmd.idx_rd) begin
      rd_a_r <= mem[addr_a];
    end
    if (cmd.load) begin
      rd_b_r <= mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_item.func;
      lit_r  <= in_item.literal;
    end
    if (cmd.mul_cap) begin
      prod_r <= DATA_W'(rd_b_r * rd_a_r);
    end
    if (cmd.commit) begin
      out_item_r.top_value <= top_c;
      out_item_r.depth     <= DEPTH_W'(sp_nxt);
      out_item_r.status    <= status_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        sp_r        <= sp_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  osa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rd_b_r),
    .divisor  (rd_a_r),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    sts          = '0;
    sts.err      = (err_c != STS_OK);
    sts.is_mul   = (func_r == FN_MUL);
    sts.is_div   = (func_r == FN_DIV);
    sts.is_idx   = (func_r == FN_INDEX);
    sts.is_exch  = (func_r == FN_EXCH);
    sts.out_free = !out_valid_r || out_ready;
    sts.div_done = div_done;
  end

  assign out_item  = out_item_r;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
